// File: src/trie_bucket_scatter_unit_assert.svh
// assertion macros for the trie bucket scatter unit
`ifndef TRIE_BUCKET_SCATTER_UNIT_ASSERT_SVH
`define TRIE_BUCKET_SCATTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TBS_ASSERT_NOW(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TBS_ASSERT_NEXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// File: src/tbs_pkg.sv
// shared constants and types for the trie bucket scatter unit
package tbs_pkg;

	localparam int TABLE_DEPTH  = 4096;
	localparam int BUFFER_DEPTH = 65536;
	localparam int TOP_SHIFT    = 56;
	localparam int RADIX_STEP   = 8;

	localparam int KEY_W   = 64;
	localparam int NODE_W  = 12;
	localparam int CHILD_W = 12;
	localparam int SLOT_W  = 16;
	localparam int DIGIT_W = 8;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int BUF_W   = $clog2(BUFFER_DEPTH);
	localparam int WP_W    = (BUF_W >= SLOT_W) ? BUF_W + 1 : SLOT_W + 1;
	localparam int SHIFT_W = $clog2(TOP_SHIFT + 1);
	localparam int WORD_W  = CHILD_W + WP_W;

	localparam logic [DIGIT_W-1:0] BYTE_MASK = 8'hff;
	localparam logic [WP_W-1:0]    WP_LIMIT  = WP_W'(BUFFER_DEPTH);
	localparam logic [SLOT_W-1:0]  SLOT_MAX  = SLOT_W'(BUFFER_DEPTH - 1);

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_SCATTER = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_WALK  = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [CHILD_W-1:0] child;
		logic [WP_W-1:0]    wp;
	} node_t;

endpackage

// File: src/tbs_ram.sv
// generic simple dual-port ram with registered read
module tbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/trie_bucket_scatter_unit.sv
// trie bucket scatter unit: node loads and key scatter through a radix-256 trie
// node load: written to the table in the cycle it is taken, no result, next request taken in the following cycle
// key scatter: one table read per trie level through the single ram read port,
// L levels walked (1 to 7 at top shift 56), result registered in S_EMIT once a leaf is
// found, a walk with no leaf ends with no result, and result stalls hold the unit in S_EMIT
// reset: after arst_n rises a clearing pass writes zero to all 4096 table
// entries, one a cycle, with in_stall high until the pass ends
module trie_bucket_scatter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [tbs_pkg::KEY_W-1:0]    key,
	input  logic                         last_key,
	input  logic [tbs_pkg::NODE_W-1:0]   node_index,
	input  logic [tbs_pkg::CHILD_W-1:0]  child_base,
	input  logic [tbs_pkg::SLOT_W-1:0]   bucket_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tbs_pkg::KEY_W-1:0]    key_out,
	output logic [tbs_pkg::SLOT_W-1:0]   slot_address,
	output logic [tbs_pkg::NODE_W-1:0]   leaf_number,
	output logic                         overflow,
	output logic                         last_out
);

	tbs_pkg::state_t                   state_q;
	logic [tbs_pkg::IDX_W-1:0]         clr_q;
	logic [tbs_pkg::KEY_W-1:0]         key_q;
	logic [tbs_pkg::KEY_W-1:0]         kshift_q;
	logic [tbs_pkg::SHIFT_W-1:0]       shift_q;
	logic [tbs_pkg::IDX_W-1:0]         idx_q;
	logic                              last_q;
	logic [tbs_pkg::WP_W-1:0]          wp_q;
	logic                              ovf_q;
	logic                              out_valid_q;
	logic [tbs_pkg::KEY_W-1:0]         key_out_q;
	logic [tbs_pkg::SLOT_W-1:0]        slot_q;
	logic [tbs_pkg::NODE_W-1:0]        leaf_q;
	logic                              overflow_q;
	logic                              last_out_q;

	logic                              in_acc;
	logic                              out_free;
	logic                              leaf_hit;
	logic                              more_levels;
	logic [tbs_pkg::DIGIT_W-1:0]       digit_in;
	logic [tbs_pkg::IDX_W-1:0]         next_idx;
	logic                              ram_we;
	logic [tbs_pkg::IDX_W-1:0]         ram_waddr;
	logic [tbs_pkg::WORD_W-1:0]        ram_wdata;
	logic [tbs_pkg::IDX_W-1:0]         ram_raddr;
	logic [tbs_pkg::WORD_W-1:0]        ram_rdata;
	tbs_pkg::node_t                    rd_node;
	tbs_pkg::node_t                    wr_node;

	assign in_stall = (state_q != tbs_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign rd_node     = tbs_pkg::node_t'(ram_rdata);
	assign leaf_hit    = (rd_node.child == '0);
	assign more_levels = (shift_q > tbs_pkg::SHIFT_W'(tbs_pkg::RADIX_STEP));
	assign digit_in    = tbs_pkg::DIGIT_W'(key >> tbs_pkg::TOP_SHIFT) & tbs_pkg::BYTE_MASK;
	// next level digit sits in the top byte of the shifted key
	assign next_idx    = tbs_pkg::IDX_W'(rd_node.child)
		+ tbs_pkg::IDX_W'(kshift_q[tbs_pkg::KEY_W-1 -: tbs_pkg::DIGIT_W] & tbs_pkg::BYTE_MASK);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		wr_node   = '0;
		ram_raddr = tbs_pkg::IDX_W'(digit_in);
		unique case (state_q)
			tbs_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			tbs_pkg::S_IDLE: begin
				if (in_acc && opcode == tbs_pkg::OP_LOAD) begin
					ram_we        = 1'b1;
					ram_waddr     = tbs_pkg::IDX_W'(node_index);
					wr_node.child = child_base;
					wr_node.wp    = tbs_pkg::WP_W'(bucket_start);
				end
			end
			tbs_pkg::S_WALK: begin
				ram_raddr = next_idx;
			end
			tbs_pkg::S_EMIT: begin
				// saturated pointer stays put
				if (out_free && !ovf_q) begin
					ram_we     = 1'b1;
					wr_node.wp = wp_q + tbs_pkg::WP_W'(1);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_wdata = wr_node;

	tbs_ram #(
		.WIDTH (tbs_pkg::WORD_W),
		.DEPTH (tbs_pkg::TABLE_DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbs_pkg::S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tbs_pkg::S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tbs_pkg::S_CLEAR: begin
					clr_q <= clr_q + tbs_pkg::IDX_W'(1);
					if (clr_q == '1) begin
						state_q <= tbs_pkg::S_IDLE;
					end
				end
				tbs_pkg::S_IDLE: begin
					if (in_acc && opcode == tbs_pkg::OP_SCATTER) begin
						state_q <= tbs_pkg::S_WALK;
					end
				end
				tbs_pkg::S_WALK: begin
					if (leaf_hit) begin
						state_q <= tbs_pkg::S_EMIT;
					end else if (!more_levels) begin
						// every level was an inner node
						state_q <= tbs_pkg::S_IDLE;
					end
				end
				tbs_pkg::S_EMIT: begin
					if (out_free) begin
						state_q <= tbs_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tbs_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tbs_pkg::S_IDLE && in_acc) begin
			key_q    <= key;
			kshift_q <= key << (tbs_pkg::KEY_W - tbs_pkg::TOP_SHIFT);
			last_q   <= last_key;
			shift_q  <= tbs_pkg::SHIFT_W'(tbs_pkg::TOP_SHIFT);
			idx_q    <= tbs_pkg::IDX_W'(digit_in);
		end
		if (state_q == tbs_pkg::S_WALK) begin
			if (leaf_hit) begin
				wp_q  <= rd_node.wp;
				ovf_q <= (rd_node.wp >= tbs_pkg::WP_LIMIT);
			end else begin
				idx_q    <= next_idx;
				shift_q  <= shift_q - tbs_pkg::SHIFT_W'(tbs_pkg::RADIX_STEP);
				kshift_q <= kshift_q << tbs_pkg::RADIX_STEP;
			end
		end
		if (state_q == tbs_pkg::S_EMIT && out_free) begin
			key_out_q  <= key_q;
			slot_q     <= ovf_q ? tbs_pkg::SLOT_MAX : tbs_pkg::SLOT_W'(wp_q);
			leaf_q     <= tbs_pkg::NODE_W'(idx_q);
			overflow_q <= ovf_q;
			last_out_q <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign key_out      = key_out_q;
	assign slot_address = slot_q;
	assign leaf_number  = leaf_q;
	assign overflow     = overflow_q;
	assign last_out     = last_out_q;

`include "trie_bucket_scatter_unit_assert.svh"

	`TBS_ASSERT_NOW(a_result_from_emit, $rose(out_valid), $past(state_q == tbs_pkg::S_EMIT),
		"result appeared without a leaf hit")
	`TBS_ASSERT_NEXT(a_emit_holds, state_q == tbs_pkg::S_EMIT && out_valid && out_stall,
		state_q == tbs_pkg::S_EMIT, "pending result overwritten")
	`TBS_ASSERT_NOW(a_clear_stalls, state_q == tbs_pkg::S_CLEAR, in_stall,
		"request taken during clearing pass")
	`TBS_ASSERT_NOW(a_walk_shift, state_q == tbs_pkg::S_WALK, shift_q != '0,
		"walk reached shift zero")
	`TBS_ASSERT_NOW(a_ovf_slot, out_valid && overflow, slot_address == tbs_pkg::SLOT_MAX,
		"overflowed result without saturated slot")

endmodule
